// ===== design/i2cee_pkg.sv =====
// Package for the I2C EEPROM master: item, result and register types, phase codes.
// No dependencies; used by the interfaces, the controller and the top level.
package i2cee_pkg;

	localparam int unsigned MaxBurst = 256;
	localparam int unsigned CountW   = 9;

	localparam logic [7:0]  DevAddrRst   = 8'ha0;
	localparam logic [15:0] HalfBitRst   = 16'd10;
	localparam logic [15:0] WriteWaitRst = 16'd200;
	localparam logic [7:0]  ReadBit      = 8'h01;

	localparam logic [1:0] RegDevAddr   = 2'd0;
	localparam logic [1:0] RegHalfBit   = 2'd1;
	localparam logic [1:0] RegWriteWait = 2'd2;

	typedef enum logic [14:0] {
		PH_IDLE  = 15'b000000000000001,
		PH_SSET  = 15'b000000000000010,
		PH_SHOLD = 15'b000000000000100,
		PH_TXL   = 15'b000000000001000,
		PH_TXH   = 15'b000000000010000,
		PH_AKL   = 15'b000000000100000,
		PH_AKH   = 15'b000000001000000,
		PH_RXL   = 15'b000000010000000,
		PH_RXH   = 15'b000000100000000,
		PH_MKL   = 15'b000001000000000,
		PH_MKH   = 15'b000010000000000,
		PH_RSL   = 15'b000100000000000,
		PH_SPL   = 15'b001000000000000,
		PH_SPH   = 15'b010000000000000,
		PH_SPE   = 15'b100000000000000
	} phase_t;

	// byte stage within a transaction; the post-write wait is a flag in the controller
	typedef enum logic [4:0] {
		ST_DEVW = 5'b00001,
		ST_AH   = 5'b00010,
		ST_AL   = 5'b00100,
		ST_DATA = 5'b01000,
		ST_DEVR = 5'b10000
	} stage_t;

	typedef struct packed {
		logic              start_request;
		logic              operation;
		logic [15:0]       mem_address;
		logic [CountW-1:0] byte_count;
		logic [7:0]        write_data;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_pull_low;
		logic       busy_res;
		logic       byte_request;
		logic [7:0] read_data;
		logic       read_valid;
		logic       done_res;
		logic       nack_error;
	} result_t;

	typedef struct packed {
		logic [7:0]  device_write_address;
		logic [15:0] half_bit_ticks;
		logic [15:0] write_wait_ticks;
	} cfg_t;

endpackage

// ===== design/i2cee_if.sv =====
// Valid/ready channel interfaces for input ticks and result items.
// Depends on i2cee_pkg for the payload types.
interface i2cee_in_if;
	logic            valid;
	logic            ready;
	i2cee_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface i2cee_out_if;
	logic               valid;
	logic               ready;
	i2cee_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/i2c_eeprom_master_top.sv =====
// The result for a tick is registered and shown in the cycle after the tick's transfer.
// Throughput: one tick per cycle; a new tick is taken while a result waits,
// as long as the result register is emptied in the same cycle.
// Bus timing comes from the half-bit and write-wait counters, not the clock.
// Reset (arst_n low): sequencer idle, counters clear, registers to defaults.
// Depends on i2cee_pkg, i2cee_if and i2cee_ctrl.
module i2c_eeprom_master_top (
	input  logic               clk,
	input  logic               arst_n,
	i2cee_in_if.sink           item,
	i2cee_out_if.source        result,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data
);

	i2cee_pkg::cfg_t    cfg_q;
	i2cee_pkg::result_t res;
	i2cee_pkg::result_t res_q;
	logic               res_valid_q;
	logic               step;

	assign item.ready = !res_valid_q || result.ready;
	assign step       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_write_address <= i2cee_pkg::DevAddrRst;
			cfg_q.half_bit_ticks       <= i2cee_pkg::HalfBitRst;
			cfg_q.write_wait_ticks     <= i2cee_pkg::WriteWaitRst;
		end else if (wr_en) begin
			unique case (wr_index)
				i2cee_pkg::RegDevAddr:   cfg_q.device_write_address <= wr_data[7:0];
				i2cee_pkg::RegHalfBit:   cfg_q.half_bit_ticks       <= wr_data;
				i2cee_pkg::RegWriteWait: cfg_q.write_wait_ticks     <= wr_data;
				default: ;
			endcase
		end
	end

	i2cee_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item.data),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== design/i2cee_ctrl.sv =====
// Bus sequencer: phase, bit and byte state, and the line drive for one tick.
// Depends on i2cee_pkg. State advances on each accepted tick.
module i2cee_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  i2cee_pkg::item_t    item,
	input  i2cee_pkg::cfg_t     cfg,
	output i2cee_pkg::result_t  res
);

	localparam logic [3:0] BitsPerByte = 4'd8;

	i2cee_pkg::phase_t phase_q, phase_d;
	i2cee_pkg::stage_t stage_q, stage_d;
	logic                         wait_q, wait_d;
	logic [15:0]                  tick_q, tick_d;
	logic [3:0]                   bit_q, bit_d;
	logic [7:0]                   shift_q, shift_d;
	logic [i2cee_pkg::CountW-1:0] left_q, left_d;
	logic [15:0]                  addr_q, addr_d;
	logic                         rd_q, rd_d;
	logic                         nack_q, nack_d;

	logic [15:0]                  half;
	logic [16:0]                  tick_inc;
	logic                         endh;
	logic                         wait_end;
	logic [3:0]                   bit_inc;
	logic [7:0]                   rx_byte;
	logic [i2cee_pkg::CountW-1:0] burst;

	always_comb begin
		half     = (cfg.half_bit_ticks == 16'd0) ? 16'd1 : cfg.half_bit_ticks;
		tick_inc = {1'b0, tick_q} + 17'd1;
		endh     = tick_inc >= {1'b0, half};
		wait_end = tick_inc >= {1'b0, cfg.write_wait_ticks};
		bit_inc  = bit_q + 4'd1;
		rx_byte  = {shift_q[6:0], item.sda_in};
		burst    = item.byte_count;
		if (burst == '0)
			burst = i2cee_pkg::CountW'(1);
		else if (burst > i2cee_pkg::CountW'(i2cee_pkg::MaxBurst))
			burst = i2cee_pkg::CountW'(i2cee_pkg::MaxBurst);
	end

	always_comb begin
		phase_d = phase_q;
		stage_d = stage_q;
		wait_d  = wait_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		left_d  = left_q;
		addr_d  = addr_q;
		rd_d    = rd_q;
		nack_d  = nack_q;
		res          = '0;
		res.scl_out  = 1'b1;
		res.busy_res = wait_q || (phase_q != i2cee_pkg::PH_IDLE);

		if (wait_q) begin
			// post-write wait: bus idle, counting ticks up to the write-wait limit
			if (wait_end) begin
				res.done_res = 1'b1;
				wait_d       = 1'b0;
				tick_d       = '0;
			end else begin
				tick_d = tick_inc[15:0];
			end
		end else begin
			unique case (phase_q)
				i2cee_pkg::PH_IDLE: begin
					if (item.start_request) begin
						left_d  = burst;
						rd_d    = item.operation;
						addr_d  = item.mem_address;
						stage_d = i2cee_pkg::ST_DEVW;
						nack_d  = 1'b0;
						phase_d = i2cee_pkg::PH_SSET;
						tick_d  = '0;
					end
				end
				i2cee_pkg::PH_RSL: begin
					res.scl_out = 1'b0;
					if (endh) begin
						phase_d = i2cee_pkg::PH_SSET;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_SSET: begin
					if (endh) begin
						phase_d = i2cee_pkg::PH_SHOLD;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_SHOLD: begin
					res.sda_pull_low = 1'b1;
					if (endh) begin
						shift_d = (stage_q == i2cee_pkg::ST_DEVR)
							? (cfg.device_write_address | i2cee_pkg::ReadBit)
							: cfg.device_write_address;
						bit_d   = '0;
						phase_d = i2cee_pkg::PH_TXL;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_TXL: begin
					res.scl_out      = 1'b0;
					res.sda_pull_low = ~shift_q[7];
					if (endh) begin
						phase_d = i2cee_pkg::PH_TXH;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_TXH: begin
					res.sda_pull_low = ~shift_q[7];
					if (endh) begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= BitsPerByte) ? i2cee_pkg::PH_AKL
							: i2cee_pkg::PH_TXL;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_AKL: begin
					res.scl_out = 1'b0;
					if (endh) begin
						phase_d = i2cee_pkg::PH_AKH;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_AKH: begin
					if (!endh) begin
						tick_d = tick_inc[15:0];
					end else if (item.sda_in) begin
						nack_d  = 1'b1;
						phase_d = i2cee_pkg::PH_SPL;
						tick_d  = '0;
					end else begin
						bit_d  = '0;
						tick_d = '0;
						unique case (stage_q)
							i2cee_pkg::ST_DEVW: begin
								stage_d = i2cee_pkg::ST_AH;
								shift_d = addr_q[15:8];
								phase_d = i2cee_pkg::PH_TXL;
							end
							i2cee_pkg::ST_AH: begin
								stage_d = i2cee_pkg::ST_AL;
								shift_d = addr_q[7:0];
								phase_d = i2cee_pkg::PH_TXL;
							end
							i2cee_pkg::ST_DEVR: begin
								shift_d = '0;
								phase_d = i2cee_pkg::PH_RXL;
							end
							i2cee_pkg::ST_AL: begin
								if (rd_q) begin
									stage_d = i2cee_pkg::ST_DEVR;
									phase_d = i2cee_pkg::PH_RSL;
								end else begin
									// first data byte
									stage_d          = i2cee_pkg::ST_DATA;
									res.byte_request = 1'b1;
									shift_d          = item.write_data;
									phase_d          = i2cee_pkg::PH_TXL;
								end
							end
							i2cee_pkg::ST_DATA: begin
								if (left_q <= i2cee_pkg::CountW'(1)) begin
									left_d  = '0;
									phase_d = i2cee_pkg::PH_SPL;
								end else begin
									left_d           = left_q - i2cee_pkg::CountW'(1);
									res.byte_request = 1'b1;
									shift_d          = item.write_data;
									phase_d          = i2cee_pkg::PH_TXL;
								end
							end
							default: begin
								phase_d = i2cee_pkg::PH_IDLE;
							end
						endcase
					end
				end
				i2cee_pkg::PH_RXL: begin
					res.scl_out = 1'b0;
					if (endh) begin
						phase_d = i2cee_pkg::PH_RXH;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_RXH: begin
					if (endh) begin
						shift_d = rx_byte;
						bit_d   = bit_inc;
						tick_d  = '0;
						if (bit_inc >= BitsPerByte) begin
							res.read_valid = 1'b1;
							res.read_data  = rx_byte;
							if (left_q != '0)
								left_d = left_q - i2cee_pkg::CountW'(1);
							phase_d = i2cee_pkg::PH_MKL;
						end else phase_d = i2cee_pkg::PH_RXL;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_MKL: begin
					res.scl_out      = 1'b0;
					res.sda_pull_low = (left_q != '0);
					if (endh) begin
						phase_d = i2cee_pkg::PH_MKH;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_MKH: begin
					// ACK while bytes remain, NACK on the last
					res.sda_pull_low = (left_q != '0);
					if (endh) begin
						tick_d = '0;
						if (left_q != '0) begin
							bit_d   = '0;
							shift_d = '0;
							phase_d = i2cee_pkg::PH_RXL;
						end else phase_d = i2cee_pkg::PH_SPL;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_SPL: begin
					res.scl_out      = 1'b0;
					res.sda_pull_low = 1'b1;
					if (endh) begin
						phase_d = i2cee_pkg::PH_SPH;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_SPH: begin
					res.sda_pull_low = 1'b1;
					if (endh) begin
						phase_d = i2cee_pkg::PH_SPE;
						tick_d  = '0;
					end else tick_d = tick_inc[15:0];
				end
				i2cee_pkg::PH_SPE: begin
					if (endh) begin
						tick_d  = '0;
						phase_d = i2cee_pkg::PH_IDLE;
						if (!nack_q && !rd_q && (cfg.write_wait_ticks != 16'd0)) begin
							wait_d = 1'b1;
						end else begin
							res.done_res   = 1'b1;
							res.nack_error = nack_q;
						end
					end else tick_d = tick_inc[15:0];
				end
				default: begin
					phase_d = i2cee_pkg::PH_IDLE;
					tick_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cee_pkg::PH_IDLE;
			stage_q <= i2cee_pkg::ST_DEVW;
			wait_q  <= 1'b0;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			addr_q  <= '0;
			rd_q    <= 1'b0;
			nack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			stage_q <= stage_d;
			wait_q  <= wait_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			left_q  <= left_d;
			addr_q  <= addr_d;
			rd_q    <= rd_d;
			nack_q  <= nack_d;
		end
	end

endmodule
